[rtl/dmwtc_pkg.sv]
// ----------------------------------------------------------------------------
// dmwtc_pkg
// Shared constants and controller/datapath interface types for the
// direct-mapped write-through cache core.
// ----------------------------------------------------------------------------
package dmwtc_pkg;

    localparam int unsigned MEM_WORDS       = 1024;
    localparam int unsigned MAX_LINES       = 16;
    localparam int unsigned MAX_BLOCK_WORDS = 8;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned TAG_W   = 10;
    localparam int unsigned LINE_W  = $clog2(MAX_LINES);
    localparam int unsigned WORD_W  = $clog2(MAX_BLOCK_WORDS);
    localparam int unsigned MEM_AW  = $clog2(MEM_WORDS);
    localparam int unsigned CACHE_DEPTH = MAX_LINES * MAX_BLOCK_WORDS;
    localparam int unsigned CACHE_AW    = LINE_W + WORD_W;
    localparam int unsigned FILL_CNT_W  = WORD_W + 1;

    localparam int unsigned BWL_W = 2;
    localparam int unsigned LCL_W = 3;
    localparam logic [BWL_W-1:0] BWL_RESET = 2'd2;
    localparam logic [LCL_W-1:0] LCL_RESET = 3'd2;
    localparam logic [LCL_W-1:0] LCL_MAX   = LCL_W'(LINE_W);

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // register index codes, decoded from paddr[2]
    localparam logic REG_BLOCK_WORDS_LOG2 = 1'b0;
    localparam logic REG_LINE_COUNT_LOG2  = 1'b1;

    localparam int unsigned S_FIELDS_W = ADDR_W + DATA_W;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_FIELDS_W = TAG_W + LINE_W + WORD_W + DATA_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic take;
        logic lookup;
        logic fill;
        logic access;
        logic out_load;
        logic init_wr;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic fill_last;
        logic init_last;
        logic out_free;
    } status_t;

endpackage

[rtl/dmwtc_ram.sv]
// ----------------------------------------------------------------------------
// dmwtc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmwtc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/dmwtc_ctrl.sv]
// ----------------------------------------------------------------------------
// dmwtc_ctrl
// Sequencer: memory init sweep, lookup, block fill, access and result load.
// ----------------------------------------------------------------------------
module dmwtc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dmwtc_pkg::status_t status,
    output dmwtc_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_LOOKUP = 6'b000100,
        ST_FILL   = 6'b001000,
        ST_ACCESS = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = status.hit ? ST_ACCESS : ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

[rtl/dmwtc_datapath.sv]
// ----------------------------------------------------------------------------
// dmwtc_datapath
// Address split, tag/valid store, cache and main memory arrays, fill counter
// and result register.
// ----------------------------------------------------------------------------
module dmwtc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmwtc_pkg::cmd_t                      cmd,
    output dmwtc_pkg::status_t                   status,
    input  logic                                 inv_all,
    input  logic [dmwtc_pkg::BWL_W-1:0]          block_words_log2,
    input  logic [dmwtc_pkg::LCL_W-1:0]          line_count_log2,
    input  logic                                 s_tuser,
    input  logic [dmwtc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic                                 m_tuser,
    output logic [dmwtc_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int unsigned ADDR_W   = dmwtc_pkg::ADDR_W;
    localparam int unsigned DATA_W   = dmwtc_pkg::DATA_W;
    localparam int unsigned LINE_W   = dmwtc_pkg::LINE_W;
    localparam int unsigned WORD_W   = dmwtc_pkg::WORD_W;
    localparam int unsigned TAG_W    = dmwtc_pkg::TAG_W;
    localparam int unsigned MEM_AW   = dmwtc_pkg::MEM_AW;
    localparam int unsigned CNT_W    = dmwtc_pkg::FILL_CNT_W;
    localparam int unsigned SHIFT_W  = dmwtc_pkg::LCL_W + 1;
    localparam int unsigned PAD_W    = dmwtc_pkg::M_TDATA_W - dmwtc_pkg::M_FIELDS_W;

    // latched request
    logic              func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic              hit_reg;

    logic [TAG_W-1:0]  tags_reg [dmwtc_pkg::MAX_LINES];
    logic [dmwtc_pkg::MAX_LINES-1:0] valid_reg;

    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  k_next;
    logic [MEM_AW-1:0] init_cnt_reg;
    logic [MEM_AW-1:0] init_cnt_next;

    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [DATA_W-1:0] out_data_reg;

    // address split
    logic [dmwtc_pkg::LCL_W-1:0] ll_eff;
    logic [SHIFT_W-1:0]          tag_shift;
    logic [LINE_W:0]             line_mask_w;
    logic [WORD_W:0]             word_mask_w;
    logic [ADDR_W-1:0]           addr_sh;
    logic [TAG_W-1:0]            tag;
    logic [LINE_W-1:0]           line;
    logic [WORD_W-1:0]           word;
    logic [ADDR_W-1:0]           base;
    logic [CNT_W-1:0]            block_words;
    logic [CNT_W-1:0]            k_m1;
    logic                        hit_now;

    // memory ports
    logic                           main_we;
    logic [MEM_AW-1:0]              main_waddr;
    logic [DATA_W-1:0]              main_wdata;
    logic [MEM_AW-1:0]              main_raddr;
    logic [DATA_W-1:0]              main_rdata;
    logic                           cache_we;
    logic [dmwtc_pkg::CACHE_AW-1:0] cache_waddr;
    logic [DATA_W-1:0]              cache_wdata;
    logic [dmwtc_pkg::CACHE_AW-1:0] cache_raddr;
    logic [DATA_W-1:0]              cache_rdata;

    // line count above the maximum behaves as the maximum
    assign ll_eff      = (line_count_log2 > dmwtc_pkg::LCL_MAX) ? dmwtc_pkg::LCL_MAX
                                                                : line_count_log2;
    assign tag_shift   = SHIFT_W'(block_words_log2) + SHIFT_W'(ll_eff);
    assign line_mask_w = ((LINE_W+1)'(1) << ll_eff) - (LINE_W+1)'(1);
    assign word_mask_w = ((WORD_W+1)'(1) << block_words_log2) - (WORD_W+1)'(1);
    assign addr_sh     = addr_reg >> block_words_log2;
    assign tag         = TAG_W'(addr_reg >> tag_shift);
    assign line        = addr_sh[LINE_W-1:0] & line_mask_w[LINE_W-1:0];
    assign word        = addr_reg[WORD_W-1:0] & word_mask_w[WORD_W-1:0];
    assign base        = addr_reg & ~ADDR_W'(word_mask_w[WORD_W-1:0]);
    assign block_words = CNT_W'(1) << block_words_log2;
    assign k_m1        = k_reg - CNT_W'(1);
    assign hit_now     = valid_reg[line] && (tags_reg[line] == tag);

    assign status.hit       = hit_now;
    assign status.fill_last = (k_reg == block_words);
    assign status.init_last = (init_cnt_reg == MEM_AW'(dmwtc_pkg::MEM_WORDS - 1));
    assign status.out_free  = !out_valid_reg || m_tready;

    // main memory: init sweep, write-through store, block fill read
    assign main_we    = cmd.init_wr || (cmd.access && func_reg);
    assign main_waddr = cmd.init_wr ? init_cnt_reg : MEM_AW'(addr_reg);
    assign main_wdata = cmd.init_wr ? (DATA_W'(dmwtc_pkg::MEM_WORDS) - DATA_W'(init_cnt_reg))
                                    : wdata_reg;
    assign main_raddr = MEM_AW'(base + ADDR_W'(k_reg));

    // fill writes the word read in the previous cycle
    assign cache_we    = (cmd.fill && (k_reg != '0)) || (cmd.access && func_reg);
    assign cache_waddr = cmd.fill ? {line, k_m1[WORD_W-1:0]} : {line, word};
    assign cache_wdata = cmd.fill ? main_rdata : wdata_reg;
    assign cache_raddr = {line, word};

    dmwtc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (dmwtc_pkg::MEM_WORDS)
    ) u_main_ram (
        .clk   (clk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    dmwtc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (dmwtc_pkg::CACHE_DEPTH)
    ) u_cache_ram (
        .clk   (clk),
        .we    (cache_we),
        .waddr (cache_waddr),
        .wdata (cache_wdata),
        .raddr (cache_raddr),
        .rdata (cache_rdata)
    );

    assign k_next        = cmd.lookup ? '0 : (cmd.fill ? k_reg + CNT_W'(1) : k_reg);
    assign init_cnt_next = cmd.init_wr ? init_cnt_reg + MEM_AW'(1) : init_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            init_cnt_reg  <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg        <= k_next;
            init_cnt_reg <= init_cnt_next;
            if (inv_all)
            begin
                valid_reg <= '0;
            end
            else if (cmd.lookup && !hit_now)
            begin
                valid_reg[line] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg  <= s_tuser;
            addr_reg  <= s_tdata[ADDR_W-1:0];
            wdata_reg <= s_tdata[ADDR_W +: DATA_W];
        end
        if (cmd.lookup)
        begin
            hit_reg <= hit_now;
            if (!hit_now)
            begin
                tags_reg[line] <= tag;
            end
        end
        if (cmd.out_load)
        begin
            out_hit_reg  <= hit_reg;
            out_tag_reg  <= tag;
            out_line_reg <= line;
            out_word_reg <= word;
            out_data_reg <= func_reg ? wdata_reg : cache_rdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_data_reg, out_word_reg, out_line_reg, out_tag_reg};

`ifndef SYNTHESIS
    // a result is never loaded over one that has not been taken
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    // fill counter stays within the block
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> (k_reg <= block_words))
        else $error("fill counter beyond block size");

    // a miss allocates the line so the same address hits afterwards
    a_miss_allocates: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lookup && !hit_now && !inv_all) |=> hit_now)
        else $error("line not allocated after miss");
`endif

endmodule

[rtl/direct_mapped_write_through_cache_core.sv]
// ----------------------------------------------------------------------------
// direct_mapped_write_through_cache_core
// The result register loads after the lookup and access states on a hit, and
// after the lookup, fill and access states on a miss (one fill word per main memory read).
// One request in flight at a time; a new request is taken while the previous
// result still waits in the result register.
// After reset a sweep loads every main memory word; no request is taken until it
// ends. Every register write invalidates all cache lines.
// ----------------------------------------------------------------------------
module direct_mapped_write_through_cache_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // apb configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dmwtc_pkg::PADDR_W-1:0]        paddr,
    input  logic [dmwtc_pkg::PDATA_W-1:0]        pwdata,
    output logic [dmwtc_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready,
    // request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic                                 s_tuser,  // func
    input  logic [dmwtc_pkg::S_TDATA_W-1:0]      s_tdata,  // address, write_data
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic                                 m_tuser,  // hit
    // tag_value, line_index, word_offset, data_word
    output logic [dmwtc_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic [dmwtc_pkg::BWL_W-1:0] bwl_reg;
    logic [dmwtc_pkg::LCL_W-1:0] lcl_reg;
    logic                        cfg_wr;
    logic                        reg_sel;

    dmwtc_pkg::cmd_t    cmd;
    dmwtc_pkg::status_t status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bwl_reg <= dmwtc_pkg::BWL_RESET;
            lcl_reg <= dmwtc_pkg::LCL_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                dmwtc_pkg::REG_BLOCK_WORDS_LOG2:
                begin
                    bwl_reg <= pwdata[dmwtc_pkg::BWL_W-1:0];
                end
                dmwtc_pkg::REG_LINE_COUNT_LOG2:
                begin
                    lcl_reg <= pwdata[dmwtc_pkg::LCL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            dmwtc_pkg::REG_BLOCK_WORDS_LOG2: prdata = dmwtc_pkg::PDATA_W'(bwl_reg);
            dmwtc_pkg::REG_LINE_COUNT_LOG2:  prdata = dmwtc_pkg::PDATA_W'(lcl_reg);
            default:                         prdata = '0;
        endcase
    end

    dmwtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // any register write changes geometry, so all lines are dropped
    dmwtc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .inv_all          (cfg_wr),
        .block_words_log2 (bwl_reg),
        .line_count_log2  (lcl_reg),
        .s_tuser          (s_tuser),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tuser          (m_tuser),
        .m_tdata          (m_tdata)
    );

endmodule

[tb/tb_direct_mapped_write_through_cache_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_write_through_cache_core
// Drives read and write requests through the cache under several geometries,
// tracks tags, valid bits, cached words and main memory alongside the core,
// and compares every result with the predicted hit, split address and word.
// ----------------------------------------------------------------------------
module tb_direct_mapped_write_through_cache_core;

    localparam int unsigned ADDR_W          = dmwtc_pkg::ADDR_W;
    localparam int unsigned DATA_W          = dmwtc_pkg::DATA_W;
    localparam int unsigned TAG_W           = dmwtc_pkg::TAG_W;
    localparam int unsigned LINE_W          = dmwtc_pkg::LINE_W;
    localparam int unsigned WORD_W          = dmwtc_pkg::WORD_W;
    localparam int unsigned BWL_W           = dmwtc_pkg::BWL_W;
    localparam int unsigned LCL_W           = dmwtc_pkg::LCL_W;
    localparam int unsigned PADDR_W         = dmwtc_pkg::PADDR_W;
    localparam int unsigned PDATA_W         = dmwtc_pkg::PDATA_W;
    localparam int unsigned S_TDATA_W       = dmwtc_pkg::S_TDATA_W;
    localparam int unsigned M_TDATA_W       = dmwtc_pkg::M_TDATA_W;
    localparam int unsigned MAX_LINES       = dmwtc_pkg::MAX_LINES;
    localparam int unsigned MAX_BLOCK_WORDS = dmwtc_pkg::MAX_BLOCK_WORDS;
    localparam int unsigned MEM_WORDS       = dmwtc_pkg::MEM_WORDS;
    localparam int unsigned CACHE_DEPTH     = dmwtc_pkg::CACHE_DEPTH;

    localparam bit ACC_READ  = 1'b0;
    localparam bit ACC_WRITE = 1'b1;

    localparam int unsigned LINE_LO = TAG_W;
    localparam int unsigned WORD_LO = TAG_W + LINE_W;
    localparam int unsigned DATA_LO = TAG_W + LINE_W + WORD_W;

    typedef struct {
        bit                func;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } access_t;

    typedef struct {
        bit                hit;
        logic [TAG_W-1:0]  tag;
        logic [LINE_W-1:0] line;
        logic [WORD_W-1:0] word;
        logic [DATA_W-1:0] data;
    } outcome_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic                 s_tuser = 1'b0;   // func
    logic [S_TDATA_W-1:0] s_tdata = '0;     // address, write_data
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 m_tuser;          // hit
    logic [M_TDATA_W-1:0] m_tdata;          // tag_value, line_index, word_offset, data_word

    // predictor state
    logic [BWL_W-1:0]  blk_log2;
    logic [LCL_W-1:0]  lines_log2;
    logic [TAG_W-1:0]  line_tag [MAX_LINES];
    bit                line_ok  [MAX_LINES];
    logic [DATA_W-1:0] cache_mem [CACHE_DEPTH];
    logic [DATA_W-1:0] main_mem  [MEM_WORDS];

    access_t  access_queue[$];
    outcome_t expected_outcomes[$];
    int       requests_open = 0;
    int       error_count = 0;
    bit       calm = 1'b0;
    int       req_gap = 0;
    int       rsp_stall = 0;

    direct_mapped_write_through_cache_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic outcome_t cache_lookup(bit func, logic [ADDR_W-1:0] addr,
                                              logic [DATA_W-1:0] wdata);
        int unsigned bl;
        int unsigned ll;
        int unsigned bwords;
        int unsigned tg;
        int unsigned ln;
        int unsigned wd;
        int unsigned base;
        int unsigned slot;
        outcome_t    r;
        bl = 32'(blk_log2);
        ll = (lines_log2 > dmwtc_pkg::LCL_MAX) ? 32'(dmwtc_pkg::LCL_MAX) : 32'(lines_log2);
        bwords = 1 << bl;
        tg = 32'(addr) >> (bl + ll);
        ln = (32'(addr) >> bl) & ((1 << ll) - 1);
        wd = 32'(addr) & (bwords - 1);
        base = 32'(addr) & ~(bwords - 1);
        slot = ln * MAX_BLOCK_WORDS;
        r.hit = line_ok[ln] && (32'(line_tag[ln]) == tg);
        // write-allocate: any miss refills the whole block first
        if (!r.hit)
        begin
            line_tag[ln] = TAG_W'(tg);
            line_ok[ln] = 1'b1;
            for (int unsigned k = 0; k < bwords; k++)
                cache_mem[slot + k] = main_mem[(base + k) % MEM_WORDS];
        end
        if (func == ACC_READ)
            r.data = cache_mem[slot + wd];
        else
        begin
            r.data = wdata;
            cache_mem[slot + wd] = wdata;
            main_mem[32'(addr) % MEM_WORDS] = wdata;
        end
        r.tag = TAG_W'(tg);
        r.line = LINE_W'(ln);
        r.word = WORD_W'(wd);
        return r;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser <= 1'b0;
            s_tdata <= '0;
            req_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (req_gap != 0)
            begin
                s_tvalid <= 1'b0;
                req_gap <= req_gap - 1;
            end
            else if (access_queue.size() != 0)
            begin
                access_t a;
                a = access_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= a.func;
                s_tdata <= S_TDATA_W'({a.wdata, a.addr});
                req_gap <= calm ? 0 : $urandom_range(0, 9);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rsp_stall <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            int s;
            s = calm ? 0 : $urandom_range(0, 9);
            rsp_stall <= s;
            m_tready <= (s == 0);
        end
        else if (rsp_stall != 0)
        begin
            rsp_stall <= rsp_stall - 1;
            m_tready <= (rsp_stall == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: register writes, accepted requests, returned results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == dmwtc_pkg::REG_BLOCK_WORDS_LOG2)
                    blk_log2 = pwdata[BWL_W-1:0];
                else
                    lines_log2 = pwdata[LCL_W-1:0];
                // geometry change drops every line, memory stays
                for (int i = 0; i < MAX_LINES; i++)
                    line_ok[i] = 1'b0;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result with no request outstanding: tdata 0x%0h", m_tdata);
                    error_count++;
                end
                else
                begin
                    outcome_t e;
                    e = expected_outcomes.pop_front();
                    check_field("hit", DATA_W'(e.hit), DATA_W'(m_tuser));
                    check_field("tag_value", DATA_W'(e.tag), DATA_W'(m_tdata[LINE_LO-1:0]));
                    check_field("line_index", DATA_W'(e.line),
                                DATA_W'(m_tdata[WORD_LO-1:LINE_LO]));
                    check_field("word_offset", DATA_W'(e.word),
                                DATA_W'(m_tdata[DATA_LO-1:WORD_LO]));
                    check_field("data_word", e.data, m_tdata[DATA_LO+DATA_W-1:DATA_LO]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_outcomes.push_back(cache_lookup(s_tuser, s_tdata[ADDR_W-1:0],
                                                         s_tdata[ADDR_W+DATA_W-1:ADDR_W]));
                requests_open--;
            end
        end
    end

    task automatic queue_access(bit func, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
        access_t a;
        a.func = func;
        a.addr = addr;
        a.wdata = wdata;
        requests_open++;
        access_queue.push_back(a);
    endtask

    task automatic drain();
        wait (requests_open == 0 && expected_outcomes.size() == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic reg_write(logic idx, logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly accesses around a hot spot so lines get reused, the rest anywhere
    task automatic random_accesses(int n, int unsigned span);
        int unsigned hot;
        int unsigned addr;
        logic [DATA_W-1:0] wd;
        hot = $urandom_range(0, MEM_WORDS - 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                hot = $urandom_range(0, MEM_WORDS - 1);
            if ($urandom_range(0, 9) < 7)
                addr = (hot + $urandom_range(0, span - 1)) % MEM_WORDS;
            else
                addr = $urandom_range(0, MEM_WORDS - 1);
            case ($urandom_range(0, 15))
                0: wd = 32'h8000_0000;
                1: wd = 32'h7fff_ffff;
                2: wd = 32'hffff_ffff;
                default: wd = $urandom();
            endcase
            queue_access($urandom_range(0, 1) ? ACC_WRITE : ACC_READ, ADDR_W'(addr), wd);
        end
    endtask

    initial
    begin
        logic [BWL_W-1:0] bwl_set [5];
        logic [LCL_W-1:0] lcl_set [5];
        int unsigned lines_used;
        bwl_set = '{2'd0, 2'd3, 2'd3, 2'd1, 2'd2};
        lcl_set = '{3'd0, 3'd4, 3'd7, 3'd5, 3'd1};
        blk_log2 = dmwtc_pkg::BWL_RESET;
        lines_log2 = dmwtc_pkg::LCL_RESET;
        for (int i = 0; i < MAX_LINES; i++)
            line_ok[i] = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++)
            main_mem[i] = DATA_W'(MEM_WORDS - i);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: 4 words per block, 4 lines
        queue_access(ACC_READ, 10'd0, 32'h0);
        queue_access(ACC_READ, 10'd3, 32'h0);
        queue_access(ACC_WRITE, 10'd1, 32'hffff_ffff);
        queue_access(ACC_READ, 10'd1, 32'h0);
        queue_access(ACC_READ, 10'd16, 32'h0);          // same line, other tag
        queue_access(ACC_READ, 10'd1, 32'h0);           // refill sees written word
        queue_access(ACC_WRITE, 10'd1023, 32'h8000_0000); // write miss allocates
        queue_access(ACC_READ, 10'd1023, 32'h0);
        queue_access(ACC_WRITE, 10'd1020, 32'h7fff_ffff);
        queue_access(ACC_READ, 10'd1020, 32'h0);
        queue_access(ACC_WRITE, 10'h155, 32'h5555_5555);
        queue_access(ACC_WRITE, 10'h2aa, 32'haaaa_aaaa);
        queue_access(ACC_READ, 10'h155, 32'h0);
        queue_access(ACC_WRITE, 10'd512, 32'h0);
        random_accesses(100, 32);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            calm = (p == 1 || p == 3);
            reg_write(dmwtc_pkg::REG_BLOCK_WORDS_LOG2,
                      {$urandom_range(0, 1) ? $urandom() : 32'h0} & ~32'h3 |
                      PDATA_W'(bwl_set[p]));
            reg_write(dmwtc_pkg::REG_LINE_COUNT_LOG2,
                      {$urandom_range(0, 1) ? $urandom() : 32'h0} & ~32'h7 |
                      PDATA_W'(lcl_set[p]));
            if (p == 0)
            begin
                // one word, one line: every new address is a miss
                queue_access(ACC_READ, 10'd0, 32'h0);
                queue_access(ACC_READ, 10'd0, 32'h0);
                queue_access(ACC_WRITE, 10'd1023, 32'h1234_5678);
                queue_access(ACC_READ, 10'd1023, 32'h0);
            end
            lines_used = 1 << ((lcl_set[p] > dmwtc_pkg::LCL_MAX) ? dmwtc_pkg::LCL_MAX
                                                                 : lcl_set[p]);
            random_accesses(100, 2 * lines_used * (1 << bwl_set[p]));
            drain();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
